// ===== design/hspd_pkg.sv =====
`default_nettype none

package hspd_pkg;

   localparam int CodeWidth     = 3;
   localparam int CountWidth    = 16;
   localparam int ToggleWidth   = 8;
   localparam int TableWidth    = 24;
   localparam int NumLines      = 3;
   localparam int CsrIndexWidth = 2;
   localparam int ReqDataWidth  = 8;
   localparam int RspDataWidth  = 56;

   localparam logic [CsrIndexWidth-1:0] CSR_FORWARD_TABLE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_REVERSE_TABLE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TOGGLE_LIMIT  = 2'd2;

   localparam logic [ToggleWidth-1:0] TOGGLE_LIMIT_RESET = 8'd200;
   localparam logic [ToggleWidth-1:0] TOGGLE_MAX         = 8'hff;

   localparam logic [CodeWidth-1:0] CODE_ALL_LOW  = 3'd0;
   localparam logic [CodeWidth-1:0] CODE_ALL_HIGH = 3'd7;

   localparam logic [1:0] DIR_NONE    = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   typedef logic [ToggleWidth-1:0] toggle_count_type [NumLines];

   typedef struct packed {
      logic [CodeWidth-1:0]  previous_code;
      logic [CountWidth-1:0] position_count;
      logic                  fault_flag;
      logic [CountWidth-1:0] speed_edge_count;
      logic [CountWidth-1:0] total_edge_count;
   } state_type;

   typedef struct packed {
      logic [CountWidth-1:0] edge_count;
      logic [CountWidth-1:0] speed_count;
      logic                  stall_event;
      logic                  fault_event;
      logic                  sensor_fault;
      logic [1:0]            step_dir;
      logic [CountWidth-1:0] position;
   } result_type;

   typedef struct packed {
      logic [TableWidth-1:0]  forward_table;
      logic [TableWidth-1:0]  reverse_table;
      logic [ToggleWidth-1:0] toggle_limit;
   } config_type;

   function automatic logic [CodeWidth-1:0] table_entry(
      input logic [TableWidth-1:0] tbl,
      input logic [CodeWidth-1:0]  idx
   );
      logic [CodeWidth-1:0] entry;
      entry = tbl[idx*CodeWidth +: CodeWidth];
      return entry;
   endfunction

endpackage

`default_nettype wire

// ===== design/hall_sensor_position_decoder_core.sv =====
`default_nettype none

// Items pass an input register and a result register on rsp_tdata. One item
// per cycle while rsp_tready is high; the two registers decouple the two
// sides, so an item is taken while a result waits.
// Reset (synchronous, active high) clears position, fault, toggle and edge
// counts, the tables to zero and the toggle limit to 200.
module hall_sensor_position_decoder_core
   import hspd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [2:0] hall_code, [3] calibration_done, [7:4] zero
   input  wire logic [ReqDataWidth-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [15:0] position, [17:16] step_dir, [18] sensor_fault, [19] fault_event,
   // [20] stall_event, [36:21] speed_count, [52:37] edge_count, [55:53] zero
   output logic [RspDataWidth-1:0]       rsp_tdata,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [TableWidth-1:0]    csr_data
);

   config_type           cfg_ff;
   state_type            state_ff;
   state_type            state_in;
   toggle_count_type     toggles_ff;
   toggle_count_type     toggles_in;
   result_type           result_in;
   result_type           result_ff;
   logic                 in_valid_ff;
   logic [CodeWidth-1:0] in_code_ff;
   logic                 in_cal_ff;
   logic                 out_valid_ff;
   logic                 advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - $bits(result_type)){1'b0}}, result_ff};

   hspd_step u_step (
      .hall_code        (in_code_ff),
      .calibration_done (in_cal_ff),
      .cfg              (cfg_ff),
      .state            (state_ff),
      .toggles          (toggles_ff),
      .state_in         (state_in),
      .toggles_in       (toggles_in),
      .result           (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_table <= '0;
         cfg_ff.reverse_table <= '0;
         cfg_ff.toggle_limit  <= TOGGLE_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FORWARD_TABLE: cfg_ff.forward_table <= csr_data;
            CSR_REVERSE_TABLE: cfg_ff.reverse_table <= csr_data;
            CSR_TOGGLE_LIMIT:  cfg_ff.toggle_limit  <= csr_data[ToggleWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         for (int i = 0; i < NumLines; i++) begin
            toggles_ff[i] <= '0;
         end
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
            toggles_ff   <= toggles_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_code_ff <= req_tdata[CodeWidth-1:0];
         in_cal_ff  <= req_tdata[CodeWidth];
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/hspd_step.sv =====
`default_nettype none

module hspd_step
   import hspd_pkg::*;
(
   input  wire logic [CodeWidth-1:0] hall_code,
   input  wire logic                 calibration_done,
   input  wire config_type           cfg,
   input  wire state_type            state,
   input  wire toggle_count_type     toggles,
   output state_type                 state_in,
   output toggle_count_type          toggles_in,
   output result_type                result
);

   logic [CodeWidth-1:0]   fwd_entry;
   logic [CodeWidth-1:0]   rev_entry;
   logic [CodeWidth-1:0]   toggled;
   logic [ToggleWidth-1:0] bumped [NumLines];
   logic [NumLines-1:0]    over;
   logic                   stall;
   logic [1:0]             dir;
   logic                   fault_ev;

   assign fwd_entry = table_entry(cfg.forward_table, state.previous_code);
   assign rev_entry = table_entry(cfg.reverse_table, state.previous_code);
   assign toggled   = hall_code ^ state.previous_code;

   always_comb begin
      state_in = state;
      dir      = DIR_NONE;
      fault_ev = 1'b0;
      if (hall_code == fwd_entry) begin
         state_in.position_count = state.position_count + 16'd1;
         state_in.fault_flag     = 1'b0;
         dir                     = DIR_FORWARD;
      end else if (hall_code == rev_entry) begin
         state_in.position_count = state.position_count - 16'd1;
         state_in.fault_flag     = 1'b0;
         dir                     = DIR_REVERSE;
      end else if (hall_code == CODE_ALL_LOW || hall_code == CODE_ALL_HIGH) begin
         state_in.fault_flag = 1'b1;
         fault_ev            = 1'b1;
      end
      state_in.speed_edge_count = calibration_done ? '0 : state.speed_edge_count + 16'd1;
      state_in.total_edge_count = state.total_edge_count + 16'd1;
      state_in.previous_code    = hall_code;
   end

   always_comb begin
      for (int i = 0; i < NumLines; i++) begin
         if (!toggled[i]) begin
            bumped[i] = '0;
         end else if (toggles[i] == TOGGLE_MAX) begin
            bumped[i] = toggles[i];
         end else begin
            bumped[i] = toggles[i] + 8'd1;
         end
         over[i] = bumped[i] > cfg.toggle_limit;
      end
      stall = |over;
      for (int i = 0; i < NumLines; i++) begin
         toggles_in[i] = stall ? '0 : bumped[i];
      end
   end

   always_comb begin
      result.position     = state_in.position_count;
      result.step_dir     = dir;
      result.sensor_fault = state_in.fault_flag;
      result.fault_event  = fault_ev;
      result.stall_event  = stall;
      result.speed_count  = state_in.speed_edge_count;
      result.edge_count   = state_in.total_edge_count;
   end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
   import hspd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [TableWidth-1:0]    csr_data = '0;

   hall_sensor_position_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // decoder shadow: configuration and state
   logic [TableWidth-1:0]  fwd_table   = '0;
   logic [TableWidth-1:0]  rev_table   = '0;
   logic [ToggleWidth-1:0] stall_limit = TOGGLE_LIMIT_RESET;
   logic [CodeWidth-1:0]   last_code   = '0;
   logic [CountWidth-1:0]  pos_count   = '0;
   logic                   fault_sticky = 1'b0;
   logic [ToggleWidth-1:0] toggle_run [NumLines] = '{default: '0};
   logic [CountWidth-1:0]  speed_edges = '0;
   logic [CountWidth-1:0]  total_edges = '0;

   result_type pending_readings [$];

   logic [CodeWidth-1:0] hall_seq [6];
   int  walk_idx = 0;
   bit  walk_fwd = 1'b1;
   bit  steady = 1'b0;

   int mismatches = 0;
   int n_edges = 0;
   int n_writes = 0;
   int n_faults = 0;
   int n_stalls = 0;
   int quiet_cycles = 0;

   function automatic result_type decode_hall_edge(logic [CodeWidth-1:0] code, logic cal);
      result_type           r;
      logic [CodeWidth-1:0] toggled;
      logic                 over;
      int                   i;
      r = '0;
      r.step_dir = DIR_NONE;
      over = 1'b0;
      if (code == fwd_table[last_code*CodeWidth +: CodeWidth]) begin
         pos_count = pos_count + 1'b1;
         fault_sticky = 1'b0;
         r.step_dir = DIR_FORWARD;
      end else if (code == rev_table[last_code*CodeWidth +: CodeWidth]) begin
         pos_count = pos_count - 1'b1;
         fault_sticky = 1'b0;
         r.step_dir = DIR_REVERSE;
      end else if (code == CODE_ALL_LOW || code == CODE_ALL_HIGH) begin
         fault_sticky = 1'b1;
         r.fault_event = 1'b1;
      end
      speed_edges = cal ? '0 : speed_edges + 1'b1;
      total_edges = total_edges + 1'b1;
      toggled = code ^ last_code;
      for (i = 0; i < NumLines; i++) begin
         if (toggled[i]) begin
            if (toggle_run[i] != TOGGLE_MAX) toggle_run[i] = toggle_run[i] + 1'b1;
         end else begin
            toggle_run[i] = '0;
         end
         if (toggle_run[i] > stall_limit) over = 1'b1;
      end
      if (over) begin
         r.stall_event = 1'b1;
         toggle_run = '{default: '0};
      end
      last_code = code;
      r.position = pos_count;
      r.sensor_fault = fault_sticky;
      r.speed_count = speed_edges;
      r.edge_count = total_edges;
      return r;
   endfunction

   task automatic compare_field(string label, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = result_type'(rsp_tdata[52:0]);
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected item expected none actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            compare_field("position", want.position, seen.position);
            compare_field("step_dir", 16'(want.step_dir), 16'(seen.step_dir));
            compare_field("sensor_fault", 16'(want.sensor_fault), 16'(seen.sensor_fault));
            compare_field("fault_event", 16'(want.fault_event), 16'(seen.fault_event));
            compare_field("stall_event", 16'(want.stall_event), 16'(seen.stall_event));
            compare_field("speed_count", want.speed_count, seen.speed_count);
            compare_field("edge_count", want.edge_count, seen.edge_count);
         end
      end
   end

   always @(posedge clock) rsp_tready <= steady || ($urandom_range(99) >= 22);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_edge(logic [CodeWidth-1:0] code, logic cal);
      result_type r;
      int gap;
      if (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(6, 1);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, cal, code};
      do @(posedge clock); while (!req_tready);
      r = decode_hall_edge(code, cal);
      if (r.fault_event) n_faults++;
      if (r.stall_event) n_stalls++;
      pending_readings.push_back(r);
      n_edges++;
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [TableWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FORWARD_TABLE: fwd_table = value;
         CSR_REVERSE_TABLE: rev_table = value;
         CSR_TOGGLE_LIMIT:  stall_limit = value[ToggleWidth-1:0];
         default: ;
      endcase
      n_writes++;
   endtask

   task automatic program_tables(logic [TableWidth-1:0] fwd, logic [TableWidth-1:0] rev,
                                 logic [ToggleWidth-1:0] limit);
      settle_block();
      write_csr(CSR_FORWARD_TABLE, fwd);
      write_csr(CSR_REVERSE_TABLE, rev);
      write_csr(CSR_TOGGLE_LIMIT, {16'b0, limit});
      csr_valid <= 1'b0;
   endtask

   task automatic program_cycle(logic [TableWidth-1:0] fill, logic [ToggleWidth-1:0] limit);
      logic [TableWidth-1:0] fwd;
      logic [TableWidth-1:0] rev;
      int k;
      fwd = fill;
      rev = fill;
      for (k = 0; k < 6; k++) begin
         fwd[hall_seq[k]*CodeWidth +: CodeWidth] = hall_seq[(k + 1) % 6];
         rev[hall_seq[k]*CodeWidth +: CodeWidth] = hall_seq[(k + 5) % 6];
      end
      program_tables(fwd, rev, limit);
   endtask

   task automatic shuffle_cycle();
      logic [CodeWidth-1:0] t;
      int i;
      int j;
      for (i = 5; i > 0; i--) begin
         j = $urandom_range(i, 0);
         t = hall_seq[i];
         hall_seq[i] = hall_seq[j];
         hall_seq[j] = t;
      end
   endtask

   task automatic walk_edges(int n);
      logic [CodeWidth-1:0] code;
      int k;
      int roll;
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            code = CodeWidth'($urandom_range(7));
         end else if (roll < 12) begin
            code = $urandom_range(1) ? CODE_ALL_HIGH : CODE_ALL_LOW;
         end else begin
            if (roll < 20) walk_fwd = !walk_fwd;
            walk_idx = walk_fwd ? (walk_idx + 1) % 6 : (walk_idx + 5) % 6;
            code = hall_seq[walk_idx];
         end
         send_edge(code, $urandom_range(99) < 10);
      end
   endtask

   task automatic toggle_line(int line, int n);
      logic [CodeWidth-1:0] code;
      int k;
      for (k = 0; k < n; k++) begin
         code = last_code ^ (3'b1 << line);
         if ($urandom_range(99) < 15) code = code ^ (3'b1 << ((line + 1) % 3));
         send_edge(code, 1'($urandom_range(1)));
      end
   endtask

   task automatic test_reset_defaults();
      send_edge(3'd0, 1'b0);
      send_edge(3'd7, 1'b1);
      send_edge(3'd5, 1'b0);
      send_edge(3'd0, 1'b0);
   endtask

   task automatic test_hall_rotation();
      hall_seq = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
      program_cycle(24'h924924, TOGGLE_LIMIT_RESET);
      send_edge(3'd1, 1'b0);
      send_edge(3'd3, 1'b0);
      send_edge(3'd2, 1'b0);
      send_edge(3'd6, 1'b0);
      send_edge(3'd4, 1'b0);
      send_edge(3'd5, 1'b0);
      send_edge(3'd1, 1'b0);
      send_edge(3'd5, 1'b1);
      send_edge(3'd4, 1'b1);
      send_edge(3'd7, 1'b0);
      send_edge(3'd0, 1'b0);
      send_edge(3'd4, 1'b0);
      send_edge(3'd1, 1'b0);
   endtask

   task automatic test_table_overlap();
      logic [TableWidth-1:0] shared;
      program_tables(24'hffffff, 24'h000000, TOGGLE_LIMIT_RESET);
      send_edge(CODE_ALL_HIGH, 1'b0);
      send_edge(CODE_ALL_LOW, 1'b0);
      send_edge(3'd3, 1'b0);
      shared = TableWidth'($urandom_range(24'hffffff));
      program_tables(shared, shared, TOGGLE_LIMIT_RESET);
      send_edge(shared[last_code*CodeWidth +: CodeWidth], 1'b0);
   endtask

   task automatic test_stall_limits();
      program_cycle(24'h924924, 8'd0);
      send_edge(last_code, 1'b0);
      send_edge(last_code ^ 3'b111, 1'b0);
      send_edge(last_code ^ 3'b001, 1'b0);
      program_cycle(24'h924924, 8'd1);
      send_edge(last_code ^ 3'b001, 1'b0);
      send_edge(last_code ^ 3'b001, 1'b0);
   endtask

   task automatic test_random_traffic();
      program_cycle(24'h924924, ToggleWidth'($urandom_range(254, 1)));
      walk_edges(100);
      shuffle_cycle();
      program_cycle(TableWidth'($urandom_range(24'hffffff)), 8'd1);
      walk_edges(60);
      toggle_line($urandom_range(2), 10);
      walk_edges(40);
      steady = 1'b1;
      program_tables(TableWidth'($urandom_range(24'hffffff)),
                     TableWidth'($urandom_range(24'hffffff)),
                     ToggleWidth'($urandom_range(4, 1)));
      walk_edges(30);
      toggle_line($urandom_range(2), 30);
      steady = 1'b0;
      shuffle_cycle();
      program_cycle(TableWidth'($urandom_range(24'hffffff)), 8'd40);
      toggle_line($urandom_range(2), 45);
      walk_edges(20);
      program_cycle(TableWidth'($urandom_range(24'hffffff)), TOGGLE_MAX);
      toggle_line($urandom_range(2), 260);
      walk_edges(20);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_hall_rotation();
      test_table_overlap();
      test_stall_limits();
      test_random_traffic();
      settle_block();
      $display("Sent %0d hall edges with %0d register writes", n_edges, n_writes);
      $display("Predicted %0d sensor faults and %0d stalls", n_faults, n_stalls);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
design/hspd_pkg.sv
design/hspd_step.sv
design/hall_sensor_position_decoder_core.sv
test/tb.sv
